// ===== sv/modem_sms_send_sequencer_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef MODEM_SMS_SEND_SEQUENCER_UNIT_DEFINES_SVH
`define MODEM_SMS_SEND_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define MSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication, off while in reset
`define MSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication that also covers reset
`define MSS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sequencer reset check failed");

`endif

// ===== sv/mss_pkg.sv =====
package mss_pkg;

  // input word kinds
  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // command codes for the string sender
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_CPIN = 3'd1;
  localparam logic [2:0] CMD_CREG = 3'd2;
  localparam logic [2:0] CMD_CSQ  = 3'd3;
  localparam logic [2:0] CMD_AT   = 3'd4;
  localparam logic [2:0] CMD_CMGF = 3'd5;
  localparam logic [2:0] CMD_CMGS = 3'd6;
  localparam logic [2:0] CMD_MSG  = 3'd7;

  // outcome codes
  localparam logic [1:0] OUTC_NONE   = 2'd0;
  localparam logic [1:0] OUTC_SENT   = 2'd1;
  localparam logic [1:0] OUTC_FAILED = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_SIGNAL     = 3'd0;
  localparam logic [2:0] CFG_MAX_SEND_TRIES = 3'd1;
  localparam logic [2:0] CFG_MAX_NET_TRIES  = 3'd2;
  localparam logic [2:0] CFG_CMD_TIMEOUT    = 3'd3;
  localparam logic [2:0] CFG_SIGNAL_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_SEND_TIMEOUT   = 3'd5;

  // configuration reset values
  localparam logic [6:0]  MIN_SIGNAL_RST     = 7'd10;
  localparam logic [2:0]  MAX_SEND_TRIES_RST = 3'd3;
  localparam logic [2:0]  MAX_NET_TRIES_RST  = 3'd3;
  localparam logic [15:0] CMD_TIMEOUT_RST    = 16'd5000;
  localparam logic [15:0] SIGNAL_TIMEOUT_RST = 16'd15000;
  localparam logic [15:0] SEND_TIMEOUT_RST   = 16'd20000;

  // saturation limits
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [2:0]  TRIES_MAX   = 3'd7;
  localparam logic [6:0]  SIG_MAX     = 7'd127;

  // reply characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // multi-character patterns tracked over reply bytes
  localparam int unsigned PAT_N   = 3;
  localparam int unsigned PAT_LEN = 5;
  localparam logic [1:0] PAT_READY = 2'd0;
  localparam logic [1:0] PAT_CSQ   = 2'd1;
  localparam logic [1:0] PAT_CMGS  = 2'd2;

  typedef struct packed {
    logic cmgs;
    logic gt;
    logic ok;
    logic csq;
    logic c5;
    logic c1;
    logic ready;
  } flags_t;

  // sequencer to tracker
  typedef struct packed {
    logic track;
    logic clear;
  } trk_ctl_t;

  // tracker to sequencer
  typedef struct packed {
    flags_t flags;
    logic   comma;
    logic   sig_pass;
  } trk_stat_t;

  // character of a pattern at a position
  function automatic logic [7:0] pat_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      PAT_READY: begin
        unique case (pos)
          3'd0: ch = 8'h52;   // R
          3'd1: ch = 8'h45;   // E
          3'd2: ch = 8'h41;   // A
          3'd3: ch = 8'h44;   // D
          3'd4: ch = 8'h59;   // Y
          default: ch = 8'h00;
        endcase
      end
      PAT_CSQ: begin
        unique case (pos)
          3'd0: ch = 8'h2B;   // +
          3'd1: ch = 8'h43;   // C
          3'd2: ch = 8'h53;   // S
          3'd3: ch = 8'h51;   // Q
          3'd4: ch = 8'h3A;   // :
          default: ch = 8'h00;
        endcase
      end
      PAT_CMGS: begin
        unique case (pos)
          3'd0: ch = 8'h2B;   // +
          3'd1: ch = 8'h43;   // C
          3'd2: ch = 8'h4D;   // M
          3'd3: ch = 8'h47;   // G
          3'd4: ch = 8'h53;   // S
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/mss_track.sv =====
module mss_track
  import mss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  trk_ctl_t  ctl,
  input  logic [7:0] rx_byte,
  input  logic [6:0] min_signal,
  output trk_stat_t stat
);

  // number parser states
  typedef enum logic [3:0] {
    NP_SKIP = 4'b0001,
    NP_POS  = 4'b0010,
    NP_NEG  = 4'b0100,
    NP_STOP = 4'b1000
  } np_t;

  logic [2:0] prog_r   [PAT_N];
  logic [2:0] prog_nxt [PAT_N];
  logic [7:0] prev_r;
  flags_t     flags_r, flags_nxt;
  logic [6:0] sig_r, sig_nxt;
  np_t        np_r, np_nxt;

  logic        is_digit, is_space, comma;
  logic [10:0] sig_sum;
  logic [6:0]  sig_add;
  logic [PAT_N-1:0] hit;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign comma    = flags_r.csq && (rx_byte == CH_COMMA);

  // value * 10 + digit, saturating
  assign sig_sum = {1'b0, sig_r, 3'b000} + {3'b000, sig_r, 1'b0} + {7'd0, rx_byte[3:0]};
  assign sig_add = (sig_sum > {4'd0, SIG_MAX}) ? SIG_MAX : sig_sum[6:0];

  // pattern progress, one tracker per pattern
  always_comb begin
    for (int i = 0; i < PAT_N; i++) begin
      if ((prog_r[i] < 3'(PAT_LEN)) && (rx_byte == pat_char(2'(i), prog_r[i]))) begin
        prog_nxt[i] = prog_r[i] + 3'd1;
      end else begin
        prog_nxt[i] = (rx_byte == pat_char(2'(i), 3'd0)) ? 3'd1 : 3'd0;
      end
      hit[i] = (prog_nxt[i] == 3'(PAT_LEN));
      if (hit[i]) begin
        prog_nxt[i] = 3'd0;
      end
    end
  end

  // signal number parser, runs after the csq header until the comma
  always_comb begin
    sig_nxt = sig_r;
    np_nxt  = np_r;
    if (flags_r.csq && !comma) begin
      unique case (np_r)
        NP_SKIP: begin
          if (is_space) begin
            np_nxt = NP_SKIP;
          end else if (rx_byte == CH_PLUS) begin
            np_nxt = NP_POS;
          end else if (rx_byte == CH_MINUS) begin
            np_nxt = NP_NEG;
          end else if (is_digit) begin
            sig_nxt = sig_add;
            np_nxt  = NP_POS;
          end else begin
            np_nxt = NP_STOP;
          end
        end
        NP_POS: begin
          if (is_digit) begin
            sig_nxt = sig_add;
          end else begin
            np_nxt = NP_STOP;
          end
        end
        NP_NEG: begin
          // a nonzero negative value stays negative
          if (is_digit) begin
            sig_nxt = sig_add;
          end else if (sig_r == 7'd0) begin
            np_nxt = NP_STOP;
          end
        end
        NP_STOP: np_nxt = NP_STOP;
        default: np_nxt = NP_STOP;
      endcase
    end
  end

  // seen flags after this byte
  always_comb begin
    flags_nxt       = flags_r;
    flags_nxt.ready = flags_r.ready | hit[PAT_READY];
    flags_nxt.csq   = flags_r.csq   | hit[PAT_CSQ];
    flags_nxt.cmgs  = flags_r.cmgs  | hit[PAT_CMGS];
    flags_nxt.c1    = flags_r.c1 | ((prev_r == CH_COMMA) && (rx_byte == CH_ONE));
    flags_nxt.c5    = flags_r.c5 | ((prev_r == CH_COMMA) && (rx_byte == CH_FIVE));
    flags_nxt.ok    = flags_r.ok | ((prev_r == CH_O) && (rx_byte == CH_K));
    flags_nxt.gt    = flags_r.gt | (rx_byte == CH_GT);
  end

  // status toward the sequencer
  assign stat.flags    = ctl.track ? flags_nxt : flags_r;
  assign stat.comma    = ctl.track && comma;
  assign stat.sig_pass = !((np_r == NP_NEG) && (sig_r != 7'd0)) && (sig_r >= min_signal);

  // tracker registers, cleared whenever a command goes out
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < PAT_N; i++) begin
        prog_r[i] <= 3'd0;
      end
      prev_r  <= 8'd0;
      flags_r <= '0;
      sig_r   <= 7'd0;
      np_r    <= NP_SKIP;
    end else if (ctl.track) begin
      for (int i = 0; i < PAT_N; i++) begin
        prog_r[i] <= prog_nxt[i];
      end
      prev_r  <= rx_byte;
      flags_r <= flags_nxt;
      sig_r   <= sig_nxt;
      np_r    <= np_nxt;
    end
  end

endmodule

// ===== sv/modem_sms_send_sequencer_unit.sv =====
// result word: registered from the input word register when the phase step is taken
// throughput: one word per cycle while the result word is not stalled; the whole
//   phase step is one pass from the input register to the result register
// reset: synchronous, active low; clears the phase, counters, timer, reply trackers,
//   both valid bits, and returns all configuration registers to their defaults
module modem_sms_send_sequencer_unit
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_command,
  output logic        out_request_accepted,
  output logic [1:0]  out_outcome,
  output logic        out_retrying,
  output logic        out_busy_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_SIM    = 8'b0000_0010,
    PH_NET    = 8'b0000_0100,
    PH_SIG    = 8'b0000_1000,
    PH_AT     = 8'b0001_0000,
    PH_TEXT   = 8'b0010_0000,
    PH_PROMPT = 8'b0100_0000,
    PH_SEND   = 8'b1000_0000
  } phase_t;

  // configuration
  logic [6:0]  min_signal_r;
  logic [2:0]  max_send_tries_r, max_net_tries_r;
  logic [15:0] cmd_timeout_r, signal_timeout_r, send_timeout_r;

  // input word register
  logic       in_v_r;
  logic [1:0] mode_r;
  logic [7:0] byte_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  send_tries_r, send_tries_nxt;
  logic [2:0]  net_tries_r, net_tries_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;

  // result word register
  logic       out_v_r;
  logic [2:0] command_r, command_nxt;
  logic       acc_r, acc_nxt;
  logic [1:0] outcome_r, outcome_nxt;
  logic       retry_r, retry_nxt;
  logic       busy_r;

  logic        step, issue, failed, can_expire;
  logic [16:0] el_inc;
  logic [15:0] limit;
  logic [2:0]  st_inc, nt_inc;
  trk_ctl_t    trk_ctl;
  trk_stat_t   trk_stat;

  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_signal_r     <= MIN_SIGNAL_RST;
      max_send_tries_r <= MAX_SEND_TRIES_RST;
      max_net_tries_r  <= MAX_NET_TRIES_RST;
      cmd_timeout_r    <= CMD_TIMEOUT_RST;
      signal_timeout_r <= SIGNAL_TIMEOUT_RST;
      send_timeout_r   <= SEND_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SIGNAL:     min_signal_r     <= cfg_wdata[6:0];
        CFG_MAX_SEND_TRIES: max_send_tries_r <= cfg_wdata[2:0];
        CFG_MAX_NET_TRIES:  max_net_tries_r  <= cfg_wdata[2:0];
        CFG_CMD_TIMEOUT:    cmd_timeout_r    <= cfg_wdata;
        CFG_SIGNAL_TIMEOUT: signal_timeout_r <= cfg_wdata;
        CFG_SEND_TIMEOUT:   send_timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      byte_r <= in_rx_byte;
    end
  end

  // reply byte trackers
  assign trk_ctl.track = step && (mode_r == MODE_BYTE) && (phase_r != PH_IDLE);
  assign trk_ctl.clear = step && issue;

  mss_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (trk_ctl),
    .rx_byte    (byte_r),
    .min_signal (min_signal_r),
    .stat       (trk_stat)
  );

  assign el_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 17'd1;
  assign st_inc = (send_tries_r == TRIES_MAX) ? send_tries_r : send_tries_r + 3'd1;
  assign nt_inc = (net_tries_r == TRIES_MAX) ? net_tries_r : net_tries_r + 3'd1;

  // tick limit for the current phase
  always_comb begin
    limit      = cmd_timeout_r;
    can_expire = 1'b1;
    if (phase_r == PH_SIG) begin
      limit      = signal_timeout_r;
      can_expire = !trk_stat.flags.csq;
    end else if (phase_r == PH_SEND) begin
      limit = send_timeout_r;
    end
  end

  // phase step for one word
  always_comb begin
    phase_nxt      = phase_r;
    send_tries_nxt = send_tries_r;
    net_tries_nxt  = net_tries_r;
    elapsed_nxt    = elapsed_r;
    command_nxt    = CMD_NONE;
    acc_nxt        = 1'b0;
    outcome_nxt    = OUTC_NONE;
    retry_nxt      = 1'b0;
    issue          = 1'b0;
    failed         = 1'b0;

    unique case (mode_r)
      MODE_REQ: begin
        if (phase_r == PH_IDLE) begin
          acc_nxt        = 1'b1;
          send_tries_nxt = 3'd0;
          net_tries_nxt  = 3'd0;
          issue          = 1'b1;
          command_nxt    = CMD_CPIN;
          phase_nxt      = PH_SIM;
        end
      end
      MODE_BYTE: begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_SIM: begin
            if (trk_stat.flags.ready) begin
              issue       = 1'b1;
              command_nxt = CMD_CREG;
              phase_nxt   = PH_NET;
            end
          end
          PH_NET: begin
            if (trk_stat.flags.c1 || trk_stat.flags.c5) begin
              net_tries_nxt = 3'd0;
              issue         = 1'b1;
              command_nxt   = CMD_CSQ;
              phase_nxt     = PH_SIG;
            end
          end
          PH_SIG: begin
            if (trk_stat.comma) begin
              if (trk_stat.sig_pass) begin
                issue       = 1'b1;
                command_nxt = CMD_AT;
                phase_nxt   = PH_AT;
              end else begin
                failed = 1'b1;
              end
            end
          end
          PH_AT: begin
            if (trk_stat.flags.ok) begin
              issue       = 1'b1;
              command_nxt = CMD_CMGF;
              phase_nxt   = PH_TEXT;
            end
          end
          PH_TEXT: begin
            if (trk_stat.flags.ok) begin
              issue       = 1'b1;
              command_nxt = CMD_CMGS;
              phase_nxt   = PH_PROMPT;
            end
          end
          PH_PROMPT: begin
            if (trk_stat.flags.gt) begin
              issue       = 1'b1;
              command_nxt = CMD_MSG;
              phase_nxt   = PH_SEND;
            end
          end
          PH_SEND: begin
            if (trk_stat.flags.cmgs && trk_stat.flags.ok) begin
              phase_nxt   = PH_IDLE;
              outcome_nxt = OUTC_SENT;
            end
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        if (phase_r != PH_IDLE) begin
          elapsed_nxt = el_inc;
          if (can_expire && (el_inc > {1'b0, limit})) begin
            if (phase_r == PH_NET) begin
              net_tries_nxt = nt_inc;
              if (nt_inc >= max_net_tries_r) begin
                failed = 1'b1;
              end else begin
                issue       = 1'b1;
                command_nxt = CMD_CREG;
              end
            end else begin
              failed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // failed attempt: restart or give up
    if (failed) begin
      send_tries_nxt = st_inc;
      if (st_inc >= max_send_tries_r) begin
        phase_nxt   = PH_IDLE;
        outcome_nxt = OUTC_FAILED;
      end else begin
        retry_nxt   = 1'b1;
        issue       = 1'b1;
        command_nxt = CMD_CPIN;
        phase_nxt   = PH_SIM;
      end
    end

    if (issue) begin
      elapsed_nxt = 17'd0;
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      send_tries_r <= 3'd0;
      net_tries_r  <= 3'd0;
      elapsed_r    <= 17'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      send_tries_r <= send_tries_nxt;
      net_tries_r  <= net_tries_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      command_r <= command_nxt;
      acc_r     <= acc_nxt;
      outcome_r <= outcome_nxt;
      retry_r   <= retry_nxt;
      busy_r    <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid            = out_v_r;
  assign out_command          = command_r;
  assign out_request_accepted = acc_r;
  assign out_outcome          = outcome_r;
  assign out_retrying         = retry_r;
  assign out_busy_res         = busy_r;

endmodule

// ===== sv/mss_checker.sv =====
`include "modem_sms_send_sequencer_unit_defines.svh"

module mss_checker
  import mss_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_command,
  input logic       out_request_accepted,
  input logic [1:0] out_outcome,
  input logic       out_retrying,
  input logic       out_busy_res
);

  // a stalled result word holds
  `MSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_command) && $stable(out_outcome))

  // a taken request always starts the sim check and leaves the unit busy
  `MSS_ASSERT_NOW(a_req_start, out_valid && out_request_accepted, (out_command == CMD_CPIN) && out_busy_res && !out_retrying)

  // a restart reissues the sim check and never reports an outcome
  `MSS_ASSERT_NOW(a_retry_cmd, out_valid && out_retrying, (out_command == CMD_CPIN) && out_busy_res && (out_outcome == OUTC_NONE))

  // any outcome ends the sequence with no command
  `MSS_ASSERT_NOW(a_outcome_idle, out_valid && (out_outcome != OUTC_NONE), !out_busy_res && (out_command == CMD_NONE))

  // no result word right after reset
  `MSS_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind modem_sms_send_sequencer_unit mss_checker u_mss_checker (.*);
